[hdl/tmq_pkg.sv]
// Shared types, sizes and helpers of the timer expiry queue.
// No dependencies; imported by the top, tmq_cfg and the testbench.
`default_nettype none
package tmq_pkg;
    localparam int CAPACITY = 32;
    localparam int IDXW     = $clog2(CAPACITY);
    localparam int CNTW     = $clog2(CAPACITY + 1);
    localparam int SUMW     = IDXW + 1;
    localparam int DW       = 64;
    localparam int TW       = 32;
    localparam int EW       = DW + TW;

    localparam logic REG_TAG    = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_NOTICE = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    typedef struct packed {
        logic [TW-1:0] tag;
        logic [TW-1:0] period;
    } t_cfg;

    // Physical slot of a logical position in the circular store.
    function automatic logic [IDXW-1:0] f_phys(input logic [IDXW-1:0] head,
                                               input logic [CNTW-1:0] pos);
        logic [SUMW-1:0] s;
        s = {1'b0, head} + SUMW'(pos);
        if (s >= SUMW'(CAPACITY)) begin
            s = s - SUMW'(CAPACITY);
        end
        return s[IDXW-1:0];
    endfunction
endpackage
`default_nettype wire

[hdl/timer_expiry_queue_top.sv]
// Top level of the timer expiry queue: sequencer around the timer store RAM.
// Depends on tmq_pkg, tmq_ram and tmq_cfg.
//
// Usage. An item is a beat on start (with i_cmd, i_deadline, i_tag) taken
// while busy is low. An add item inserts a timer into a deadline-ordered
// circular store held in one RAM; a tick item advances the 64-bit counter and
// removes every due timer from the head of the store. Each result beat sits on
// the o_ ports for one cycle with o_result_valid high; the receiver cannot
// stall, so every beat must be taken when shown. The last beat of each item
// has o_last set and carries the task-switch or dropped flag.
// Steps run with busy high; the closing beat is shown in the cycle after the
// last. An add reads, compares and shifts each entry deadline-greater than the
// new one, writing the new timer in the compare that ends the walk, or in a read
// step at the head; an add to a full store goes straight to closing. A tick reads
// and compares each removed timer and the one that stops the scan (only a read
// when the store runs empty), then takes a re-arm step per re-armed task timer
// plus its insert, a last re-arm step to leave, and a closing step. All are bound
// by the single RAM read port with registered read data: a read is issued, the
// compare and write-back happen the cycle after. Inserts shift entries toward
// the tail one at a time. busy stays high from the accepted beat until the
// closing result is shown; a new item may be taken in that same cycle.
// Reset clears the counter, entry count, head pointer and control registers, not
// the data registers; the RAM is not cleared since only live entries are ever read.
// Configuration writes are expected only while busy is low.
`default_nettype none
module timer_expiry_queue_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic         i_cmd,
    input  wire logic [63:0]  i_deadline,
    input  wire logic [31:0]  i_tag,
    output logic              o_result_valid,
    output logic              o_kind,
    output logic      [63:0]  o_expired_deadline,
    output logic      [31:0]  o_expired_tag,
    output logic              o_task_switch,
    output logic              o_add_dropped,
    output logic              o_last,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import tmq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_RD   = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_REARM    = 3'd5;
    localparam logic [2:0] S_CLOSE    = 3'd6;

    t_cfg cfg;

    logic [2:0]      r_state, n_state;
    logic [DW-1:0]   r_tick, n_tick;
    logic [CNTW-1:0] r_count, n_count;
    logic [IDXW-1:0] r_head, n_head;
    logic [CNTW-1:0] r_pos, n_pos;
    logic [DW-1:0]   r_ins_d, n_ins_d;
    logic [TW-1:0]   r_ins_t, n_ins_t;
    logic            r_is_tick, n_is_tick;
    logic [CNTW-1:0] r_rearm, n_rearm;
    logic            r_sw, n_sw;
    logic            r_drop, n_drop;

    logic            n_ov, n_kind, n_tsw, n_adrop, n_last;
    logic [DW-1:0]   n_odl;
    logic [TW-1:0]   n_otag;

    logic            mem_we;
    logic [IDXW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0]   mem_wdata, mem_rdata;
    logic [DW-1:0]   rd_d;
    logic [TW-1:0]   rd_t;
    logic [DW:0]     rearm_sum;

    tmq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tmq_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign rd_d      = mem_rdata[EW-1:TW];
    assign rd_t      = mem_rdata[TW-1:0];
    assign rearm_sum = {1'b0, r_tick} + {{(DW+1-TW){1'b0}}, cfg.period};

    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_count   = r_count;
        n_head    = r_head;
        n_pos     = r_pos;
        n_ins_d   = r_ins_d;
        n_ins_t   = r_ins_t;
        n_is_tick = r_is_tick;
        n_rearm   = r_rearm;
        n_sw      = r_sw;
        n_drop    = r_drop;
        n_ov      = 1'b0;
        n_kind    = KIND_NOTICE;
        n_odl     = '0;
        n_otag    = '0;
        n_tsw     = 1'b0;
        n_adrop   = 1'b0;
        n_last    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = {r_ins_d, r_ins_t};
        mem_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_sw    = 1'b0;
                    n_drop  = 1'b0;
                    n_rearm = '0;
                    if (i_cmd == CMD_TICK) begin
                        n_is_tick = 1'b1;
                        n_tick    = r_tick + DW'(1);
                        n_state   = S_SCAN_RD;
                    end else begin
                        n_is_tick = 1'b0;
                        if (r_count == CNTW'(CAPACITY)) begin
                            n_drop  = 1'b1;
                            n_state = S_CLOSE;
                        end else begin
                            n_ins_d = i_deadline;
                            n_ins_t = i_tag;
                            n_pos   = r_count;
                            n_state = S_INS_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_head;
                    n_count   = r_count + CNTW'(1);
                    n_state   = r_is_tick ? S_REARM : S_CLOSE;
                end else begin
                    mem_raddr = f_phys(r_head, r_pos - CNTW'(1));
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = f_phys(r_head, r_pos);
                if (rd_d > r_ins_d) begin
                    mem_wdata = mem_rdata;
                    n_pos     = r_pos - CNTW'(1);
                    n_state   = S_INS_RD;
                end else begin
                    n_count = r_count + CNTW'(1);
                    n_state = r_is_tick ? S_REARM : S_CLOSE;
                end
            end
            S_SCAN_RD: begin
                mem_raddr = r_head;
                n_state   = (r_count == '0) ? S_REARM : S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (rd_d <= r_tick) begin
                    n_head  = f_phys(r_head, CNTW'(1));
                    n_count = r_count - CNTW'(1);
                    if (rd_t == cfg.tag) begin
                        n_rearm = r_rearm + CNTW'(1);
                        n_sw    = 1'b1;
                    end else begin
                        n_ov   = 1'b1;
                        n_odl  = rd_d;
                        n_otag = rd_t;
                    end
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_REARM;
                end
            end
            S_REARM: begin
                if (r_rearm == '0) begin
                    n_state = S_CLOSE;
                end else begin
                    // Re-armed deadline saturates at the top of the counter range.
                    n_rearm = r_rearm - CNTW'(1);
                    n_ins_d = rearm_sum[DW] ? {DW{1'b1}} : rearm_sum[DW-1:0];
                    n_ins_t = cfg.tag;
                    n_pos   = r_count;
                    n_state = S_INS_RD;
                end
            end
            S_CLOSE: begin
                n_ov    = 1'b1;
                n_kind  = KIND_CLOSE;
                n_tsw   = r_is_tick && r_sw;
                n_adrop = !r_is_tick && r_drop;
                n_last  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tick         <= '0;
            r_count        <= '0;
            r_head         <= '0;
            r_pos          <= '0;
            r_is_tick      <= 1'b0;
            r_rearm        <= '0;
            r_sw           <= 1'b0;
            r_drop         <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_tick         <= n_tick;
            r_count        <= n_count;
            r_head         <= n_head;
            r_pos          <= n_pos;
            r_is_tick      <= n_is_tick;
            r_rearm        <= n_rearm;
            r_sw           <= n_sw;
            r_drop         <= n_drop;
            o_result_valid <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins_d            <= n_ins_d;
        r_ins_t            <= n_ins_t;
        o_kind             <= n_kind;
        o_expired_deadline <= n_odl;
        o_expired_tag      <= n_otag;
        o_task_switch      <= n_tsw;
        o_add_dropped      <= n_adrop;
        o_last             <= n_last;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |=> !o_result_valid)
        else $error("result beat right after a closing beat");

    a_close_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |-> !busy)
        else $error("closing beat shown while still busy");
`endif
endmodule
`default_nettype wire

[hdl/tmq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module tmq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 96,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/tmq_cfg.sv]
// APB-style register port holding the task timer tag and re-arm period.
// Depends on tmq_pkg.
`default_nettype none
module tmq_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output tmq_pkg::t_cfg     o_cfg
);
    import tmq_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tag    <= 32'h8000_0000;
            r_cfg.period <= 32'd2;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TAG:    r_cfg.tag    <= pwdata;
                REG_PERIOD: r_cfg.period <= pwdata;
                default:    r_cfg.tag    <= r_cfg.tag;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TAG:    prdata = r_cfg.tag;
            REG_PERIOD: prdata = r_cfg.period;
            default:    prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

[bench/tb_timer_expiry_queue_top.sv]
// Self-checking testbench of the timer expiry queue: directed table and phases, then random beats.
// Depends on tmq_pkg and timer_expiry_queue_top; predicts results with a local model.
`default_nettype none
module tb_timer_expiry_queue_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tmq_pkg::*;

    // Byte addresses of the two registers.
    localparam logic [2:0] ADDR_TAG    = 3'd0;
    localparam logic [2:0] ADDR_PERIOD = 3'd4;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 68;
    localparam logic [63:0] DMAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = 1'b0;
    logic [63:0] i_deadline = '0;
    logic [31:0] i_tag = '0;
    logic        o_result_valid, o_kind, o_task_switch, o_add_dropped, o_last;
    logic [63:0] o_expired_deadline;
    logic [31:0] o_expired_tag;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    timer_expiry_queue_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_deadline(i_deadline), .i_tag(i_tag),
        .o_result_valid(o_result_valid), .o_kind(o_kind),
        .o_expired_deadline(o_expired_deadline), .o_expired_tag(o_expired_tag),
        .o_task_switch(o_task_switch), .o_add_dropped(o_add_dropped),
        .o_last(o_last), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One result beat as the block shows it.
    typedef struct packed {
        logic        kind;
        logic [63:0] exp_deadline;
        logic [31:0] exp_tag;
        logic        task_switch;
        logic        add_dropped;
        logic        last;
    } t_notice;

    // Local copy of the queue state and the registers.
    logic [31:0] mdl_tag_reg;
    logic [31:0] mdl_period_reg;
    logic [63:0] mdl_ticks;
    logic [63:0] mdl_deadlines[$];
    logic [31:0] mdl_tags[$];

    t_notice pending_results[$];
    int      mismatches = 0;
    int      notices_seen = 0;
    int      closes_seen = 0;
    int      drops_seen = 0;
    int      switches_seen = 0;
    longint unsigned cycle_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR t=%0t %s: got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Ordered insert, after equal deadlines; refused when the store is full.
    function automatic bit timer_insert(input logic [63:0] d, input logic [31:0] t);
        int p;
        if (mdl_deadlines.size() >= CAPACITY) return 1'b0;
        p = mdl_deadlines.size();
        while (p > 0 && mdl_deadlines[p-1] > d) p--;
        mdl_deadlines.insert(p, d);
        mdl_tags.insert(p, t);
        return 1'b1;
    endfunction

    // Works out the results of one accepted beat and queues them.
    task automatic predict_timer_beat(input logic cmd, input logic [63:0] d,
                                      input logic [31:0] t);
        t_notice r;
        logic [63:0] due_d[$];
        logic [31:0] due_t[$];
        logic [63:0] nd;
        bit sw;
        bit ok;
        sw = 1'b0;
        if (cmd == CMD_ADD) begin
            ok = timer_insert(d, t);
            r = '{KIND_CLOSE, 64'd0, 32'd0, 1'b0, !ok, 1'b1};
            pending_results.push_back(r);
            return;
        end
        mdl_ticks = mdl_ticks + 64'd1;
        while (mdl_deadlines.size() > 0 && mdl_deadlines[0] <= mdl_ticks) begin
            due_d.push_back(mdl_deadlines.pop_front());
            due_t.push_back(mdl_tags.pop_front());
        end
        foreach (due_d[i]) begin
            if (due_t[i] == mdl_tag_reg) begin
                nd = mdl_ticks + {32'd0, mdl_period_reg};
                if (nd < mdl_ticks) nd = DMAX;   // re-arm saturates
                ok = timer_insert(nd, due_t[i]);
                sw = 1'b1;
            end else begin
                r = '{KIND_NOTICE, due_d[i], due_t[i], 1'b0, 1'b0, 1'b0};
                pending_results.push_back(r);
            end
        end
        r = '{KIND_CLOSE, 64'd0, 32'd0, sw, 1'b0, 1'b1};
        pending_results.push_back(r);
    endtask

    // Result monitor: every strobe is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_notice want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", {63'd0, o_kind}, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_kind != want.kind)
                    report_mismatch("kind", 64'(o_kind), 64'(want.kind));
                if (o_expired_deadline != want.exp_deadline)
                    report_mismatch("expired_deadline", o_expired_deadline,
                                    want.exp_deadline);
                if (o_expired_tag != want.exp_tag)
                    report_mismatch("expired_tag", 64'(o_expired_tag),
                                    64'(want.exp_tag));
                if (o_task_switch != want.task_switch)
                    report_mismatch("task_switch", 64'(o_task_switch),
                                    64'(want.task_switch));
                if (o_add_dropped != want.add_dropped)
                    report_mismatch("add_dropped", 64'(o_add_dropped),
                                    64'(want.add_dropped));
                if (o_last != want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
                if (o_kind == KIND_NOTICE) notices_seen++;
                else closes_seen++;
                if (o_add_dropped) drops_seen++;
                if (o_task_switch) switches_seen++;
            end
        end
    end

    // Watchdog against a hung block.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // Register write: setup then access cycle, driven on falling edges.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_TAG) mdl_tag_reg = value;
        else mdl_period_reg = value;
    endtask

    // Drives one beat on start and waits for its acceptance. The beat always
    // starts on a fresh falling edge, so start is never driven twice at once.
    task automatic send_timer_beat(input logic cmd, input logic [63:0] d,
                                   input logic [31:0] t, input int gap);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        start <= 1'b1; i_cmd <= cmd; i_deadline <= d; i_tag <= t;
        do @(posedge i_clk); while (busy);
        predict_timer_beat(cmd, d, t);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Lets all expected results drain before a register write or the end of the test.
    task automatic wait_until_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Directed stimulus: cmd, deadline, tag, then the closing flags typed in
    // where they are obvious at a glance (has_exp set); other rows rely on
    // the predictor alone.
    typedef struct {
        logic        cmd;
        logic [63:0] deadline;
        logic [31:0] tag;
        logic        has_exp;
        logic        exp_sw;
        logic        exp_drop;
    } t_row;

    t_row directed_rows[] = '{
        '{CMD_TICK, 64'd0, 32'd0,         1'b1, 1'b0, 1'b0}, // tick on an empty store
        '{CMD_ADD,  64'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0}, // already overdue
        '{CMD_ADD,  DMAX,  32'h8000_0000, 1'b0, 1'b0, 1'b0}, // largest deadline
        '{CMD_ADD,  64'd3, 32'h0000_0001, 1'b0, 1'b0, 1'b0},
        '{CMD_ADD,  64'd3, 32'h0000_0002, 1'b0, 1'b0, 1'b0}, // equal deadline, keeps order
        '{CMD_ADD,  64'd2, 32'h8000_0000, 1'b0, 1'b0, 1'b0}, // task timer
        '{CMD_TICK, DMAX,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}, // fields ignored on tick
        '{CMD_TICK, 64'd0, 32'd0,         1'b0, 1'b0, 1'b0},
        '{CMD_TICK, 64'd0, 32'd0,         1'b0, 1'b0, 1'b0},
        '{CMD_TICK, 64'd0, 32'd0,         1'b0, 1'b0, 1'b0},
        '{CMD_TICK, 64'd0, 32'd0,         1'b0, 1'b0, 1'b0}
    };

    initial begin
        logic [63:0] d;
        logic [31:0] t;
        int n;
        t_notice last_r;
        mdl_tag_reg = 32'h8000_0000;
        mdl_period_reg = 32'd2;
        mdl_ticks = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_timer_beat(directed_rows[i].cmd, directed_rows[i].deadline,
                            directed_rows[i].tag, $urandom_range(0, 3));
            if (directed_rows[i].has_exp) begin
                last_r = pending_results[$];
                if (last_r.task_switch != directed_rows[i].exp_sw)
                    report_mismatch("typed task_switch", 64'(last_r.task_switch),
                                    64'(directed_rows[i].exp_sw));
                if (last_r.add_dropped != directed_rows[i].exp_drop)
                    report_mismatch("typed add_dropped", 64'(last_r.add_dropped),
                                    64'(directed_rows[i].exp_drop));
            end
        end

        // Fill the store past capacity so that adds are dropped.
        for (int i = 0; i < CAPACITY + 2; i++)
            send_timer_beat(CMD_ADD, mdl_ticks + 64'd40 + $urandom_range(0, 5),
                            $urandom, 0);
        wait_until_idle();

        // Period zero: a task timer is due again at once but waits a tick.
        write_register(ADDR_PERIOD, 32'd0);
        write_register(ADDR_TAG, 32'h0000_0055);
        repeat (50) send_timer_beat(CMD_TICK, 64'd0, 32'd0, $urandom_range(0, 2));
        send_timer_beat(CMD_ADD, mdl_ticks + 1, 32'h55, 0);
        send_timer_beat(CMD_ADD, mdl_ticks + 1, 32'h55, 0);
        repeat (3) send_timer_beat(CMD_TICK, 64'd0, 32'd0, 0);
        wait_until_idle();

        // Largest period: re-arm lands far out.
        write_register(ADDR_PERIOD, 32'hFFFF_FFFF);
        repeat (3) send_timer_beat(CMD_TICK, 64'd0, 32'd0, 0);
        wait_until_idle();

        // Random phases over several register settings, small periods mostly.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin write_register(ADDR_TAG, 32'h7FFF_FFFF);
                         write_register(ADDR_PERIOD, 32'd1); end
                1: begin write_register(ADDR_TAG, 32'h8000_0000);
                         write_register(ADDR_PERIOD, 32'd3); end
                2: begin write_register(ADDR_TAG, $urandom);
                         write_register(ADDR_PERIOD, $urandom_range(1, 6)); end
                default: begin write_register(ADDR_TAG, 32'h0000_0007);
                         write_register(ADDR_PERIOD, 32'd2); end
            endcase
            for (int i = 0; i < RANDOM_BEATS / 4; i++) begin
                n = $urandom_range(0, 15);
                if ($urandom_range(0, 9) < 4) begin
                    send_timer_beat(CMD_TICK, {$urandom, $urandom}, $urandom,
                                    (i % 10 < 3) ? 0 : $urandom_range(0, 15));
                end else begin
                    d = mdl_ticks + $urandom_range(0, 8);
                    if ($urandom_range(0, 15) == 0) d = {$urandom, $urandom};
                    t = ($urandom_range(0, 3) == 0) ? mdl_tag_reg : $urandom;
                    send_timer_beat(CMD_ADD, d, t,
                                    (i % 10 < 3) ? 0 : n);
                end
            end
            wait_until_idle();
        end

        // Counter wrap: bringing the counter near the top is not reachable by
        // ticking, so no stimulus here reaches the wrap; a last run of ticks follows.
        repeat (10) send_timer_beat(CMD_TICK, 64'd0, 32'd0, 0);
        wait_until_idle();

        $display("covered %0d notices, %0d closing beats, %0d drops, %0d task switches",
                 notices_seen, closes_seen, drops_seen, switches_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
